// ----- hw/rtl/stim_pkg.sv -----
package stim_pkg;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_S2T      = 2'd1,
        OP_T2S      = 2'd2,
        OP_RESERVED = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_MONO    = 2'd1,
        ST_UNAVAILABLE = 2'd2,
        ST_RESERVED    = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [63:0] sample_index;
        logic signed [63:0] time_stamp;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [63:0] result_value;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_RD,
        S_ADD_WAIT,
        S_ADD_CHK,
        S_SRCH_RD,
        S_SRCH_WAIT,
        S_SRCH_CMP,
        S_PAIR_RD0,
        S_PAIR_RD1,
        S_PAIR_WAIT,
        S_PAIR_CAP,
        S_ONE_RD,
        S_ONE_WAIT,
        S_ONE_CAP,
        S_MUL,
        S_DIV,
        S_ROUND,
        S_SUM,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;     // capture request
        logic rd_last;      // read entry n-1 (add check)
        logic rd_mid;       // read search midpoint
        logic rd_lo;        // read entry lo
        logic rd_lo1;       // read entry lo+1
        logic rd_zero;      // read entry 0
        logic add_chk;      // judge the add and write
        logic srch_init;
        logic srch_step;
        logic pair_clamp;
        logic pair_cap;
        logic one_cap;
        logic mul_go;
        logic div_step;
        logic do_round;
        logic do_sum;
        logic set_unavail;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       cnt_zero;
        logic       cnt_one;
        logic       rate_zero;
        logic       srch_done;
        logic       div_done;
        logic       span_zero;
    } stat_t;

endpackage

// ----- hw/rtl/stim_ctrl.sv -----
module stim_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  stim_pkg::stat_t st,
    output stim_pkg::ctrl_t cmd
);

    stim_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stim_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    // new request only when idle and the result slot is free
    assign in_stall  = !((state_reg == stim_pkg::S_IDLE) && !out_valid_reg);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            stim_pkg::S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = stim_pkg::S_DECODE;
                end
            end
            stim_pkg::S_DECODE:
            begin
                if (st.opcode == stim_pkg::OP_ADD)
                begin
                    if (st.cnt_zero)
                    begin
                        cmd.add_chk = 1'b1;
                        state_next  = stim_pkg::S_OUT;
                    end
                    else
                        state_next = stim_pkg::S_ADD_RD;
                end
                else if (st.opcode == stim_pkg::OP_RESERVED || st.cnt_zero
                         || (st.cnt_one && st.rate_zero))
                begin
                    cmd.set_unavail = 1'b1;
                    state_next      = stim_pkg::S_OUT;
                end
                else if (st.cnt_one)
                    state_next = stim_pkg::S_ONE_RD;
                else
                begin
                    cmd.srch_init = 1'b1;
                    state_next    = stim_pkg::S_SRCH_RD;
                end
            end
            stim_pkg::S_ADD_RD:
            begin
                cmd.rd_last = 1'b1;
                state_next  = stim_pkg::S_ADD_WAIT;
            end
            stim_pkg::S_ADD_WAIT: state_next = stim_pkg::S_ADD_CHK;
            stim_pkg::S_ADD_CHK:
            begin
                cmd.add_chk = 1'b1;
                state_next  = stim_pkg::S_OUT;
            end
            stim_pkg::S_SRCH_RD:
            begin
                if (st.srch_done)
                begin
                    cmd.pair_clamp = 1'b1;
                    state_next     = stim_pkg::S_PAIR_RD0;
                end
                else
                begin
                    cmd.rd_mid = 1'b1;
                    state_next = stim_pkg::S_SRCH_WAIT;
                end
            end
            stim_pkg::S_SRCH_WAIT: state_next = stim_pkg::S_SRCH_CMP;
            stim_pkg::S_SRCH_CMP:
            begin
                cmd.srch_step = 1'b1;
                state_next    = stim_pkg::S_SRCH_RD;
            end
            stim_pkg::S_PAIR_RD0:
            begin
                cmd.rd_lo  = 1'b1;
                state_next = stim_pkg::S_PAIR_RD1;
            end
            stim_pkg::S_PAIR_RD1:
            begin
                cmd.rd_lo1 = 1'b1;
                state_next = stim_pkg::S_PAIR_WAIT;
            end
            stim_pkg::S_PAIR_WAIT: state_next = stim_pkg::S_PAIR_CAP;
            stim_pkg::S_PAIR_CAP:
            begin
                cmd.pair_cap = 1'b1;
                state_next   = stim_pkg::S_MUL;
            end
            stim_pkg::S_ONE_RD:
            begin
                cmd.rd_zero = 1'b1;
                state_next  = stim_pkg::S_ONE_WAIT;
            end
            stim_pkg::S_ONE_WAIT: state_next = stim_pkg::S_ONE_CAP;
            stim_pkg::S_ONE_CAP:
            begin
                cmd.one_cap = 1'b1;
                state_next  = stim_pkg::S_MUL;
            end
            stim_pkg::S_MUL:
            begin
                if (st.span_zero)
                    state_next = stim_pkg::S_SUM;
                else
                begin
                    cmd.mul_go = 1'b1;
                    state_next = stim_pkg::S_DIV;
                end
            end
            stim_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_done)
                    state_next = stim_pkg::S_ROUND;
            end
            stim_pkg::S_ROUND:
            begin
                cmd.do_round = 1'b1;
                state_next   = stim_pkg::S_SUM;
            end
            stim_pkg::S_SUM:
            begin
                cmd.do_sum = 1'b1;
                state_next = stim_pkg::S_OUT;
            end
            stim_pkg::S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next     = stim_pkg::S_IDLE;
                end
            end
            default: state_next = stim_pkg::S_IDLE;
        endcase
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != stim_pkg::S_IDLE) |-> in_stall)
        else $error("request accepted while busy");
    a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == stim_pkg::S_OUT)
        else $error("result raised outside output state");
    a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> state_reg == stim_pkg::S_IDLE)
        else $error("controller not idle after result");

endmodule

// ----- hw/rtl/stim_datapath.sv -----
module stim_datapath #(
    parameter int unsigned TABLE_DEPTH      = 1024,
    parameter longint unsigned TICKS_PER_SECOND = 64'd1073741824
) (
    input  logic                clk,
    input  logic                rst_n,
    input  stim_pkg::in_item_t  in_data,
    input  logic [47:0]         rate_cfg,
    input  stim_pkg::ctrl_t     cmd,
    output stim_pkg::stat_t     st,
    output stim_pkg::out_item_t out_data
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [63:0] SIGN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] TICK_SCALE = 64'(TICKS_PER_SECOND) << 16;

    // anchor memories, one write and one read port each
    logic [63:0] mem_s [TABLE_DEPTH];
    logic [63:0] mem_t [TABLE_DEPTH];
    logic [63:0] rd_s_reg, rd_t_reg;
    logic [AW-1:0] raddr;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] waddr;

    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    op_reg;
    logic [63:0]   s_reg, t_reg;
    logic [AW-1:0] lo_reg, hi_reg, mid_reg;
    logic [63:0]   s0_reg, t0_reg;
    logic [1:0]    status_reg, status_next;
    logic [63:0]   result_reg;

    // multiply operands and divider state
    logic [63:0]   ma_reg, mb_reg, dv_reg, base_reg;
    logic          neg_reg, round_reg, span_zero_reg;
    logic [127:0]  num_reg;
    logic [63:0]   rem_reg;
    logic [127:0]  quo_reg;
    logic [7:0]    bit_reg;
    logic [1:0]    mul_ph_reg;
    logic [63:0]   pp_reg [4];

    logic [CW-1:0] n_eff;
    logic [AW-1:0] last_addr;
    logic [AW-1:0] mid_calc;
    logic [AW:0]   mid_sum;

    assign n_eff     = (count_reg >= DEPTH_C) ? DEPTH_C - CW'(1) : count_reg;
    assign last_addr = AW'(n_eff - CW'(1));
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg} + (AW+1)'(1);
    assign mid_calc  = mid_sum[AW:1];

    always_comb
    begin
        rd_en = 1'b1;
        priority if (cmd.rd_last) raddr = last_addr;
        else if (cmd.rd_mid)  raddr = mid_calc;
        else if (cmd.rd_lo)   raddr = lo_reg;
        else if (cmd.rd_lo1)  raddr = lo_reg + AW'(1);
        else
        begin
            raddr = '0;
            rd_en = cmd.rd_zero;
        end
    end

    function automatic logic slt(input logic [63:0] a, input logic [63:0] b);
        return (a ^ SIGN) < (b ^ SIGN);
    endfunction

    function automatic logic [64:0] sdiff(input logic [63:0] a, input logic [63:0] b);
        // {neg, magnitude}
        if (!slt(a, b)) return {1'b0, a - b};
        else            return {1'b1, b - a};
    endfunction

    // add judgment
    logic          add_ok, add_rej;
    logic [CW-1:0] add_n;
    always_comb
    begin
        add_n   = n_eff;
        add_rej = 1'b0;
        if (count_reg != '0)
        begin
            if (s_reg == rd_s_reg) add_n = n_eff - CW'(1);
            else if (slt(s_reg, rd_s_reg)) add_rej = 1'b1;
        end
        add_ok = !add_rej;
    end
    assign wr_en = cmd.add_chk && add_ok;
    assign waddr = AW'(add_n);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_s[waddr] <= s_reg;
            mem_t[waddr] <= t_reg;
        end
        if (rd_en)
        begin
            rd_s_reg <= mem_s[raddr];
            rd_t_reg <= mem_t[raddr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (wr_en) count_next = add_n + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) count_reg <= '0;
        else        count_reg <= count_next;
    end

    logic [63:0] key;
    logic [63:0] mid_x;
    assign key   = (op_reg == stim_pkg::OP_S2T) ? s_reg : t_reg;
    assign mid_x = (op_reg == stim_pkg::OP_S2T) ? rd_s_reg : rd_t_reg;

    // left anchor from s0/t0, right anchor straight from the read register
    logic [64:0] dk, ds, dt;
    logic [63:0] x0, x1, y0, y1;
    assign x0 = (op_reg == stim_pkg::OP_S2T) ? s0_reg : t0_reg;
    assign x1 = (op_reg == stim_pkg::OP_S2T) ? rd_s_reg : rd_t_reg;
    assign y0 = (op_reg == stim_pkg::OP_S2T) ? t0_reg : s0_reg;
    assign y1 = (op_reg == stim_pkg::OP_S2T) ? rd_t_reg : rd_s_reg;
    assign dk = sdiff(key, x0);
    assign ds = sdiff(x1, x0);
    assign dt = sdiff(y1, y0);

    logic [64:0] d1;
    assign d1 = (op_reg == stim_pkg::OP_S2T) ? sdiff(s_reg, rd_s_reg)
                                             : sdiff(t_reg, rd_t_reg);

    // one radix-2 restoring step
    logic [64:0] rem_sh;
    logic        q_bit;
    logic [64:0] rem_sub;
    assign rem_sh  = {rem_reg, num_reg[127]};
    assign q_bit   = rem_sh >= {1'b0, dv_reg};
    assign rem_sub = rem_sh - {1'b0, dv_reg};

    // saturating sum
    logic [63:0] yb;
    logic [63:0] sum_res;
    logic [64:0] up;
    always_comb
    begin
        yb = base_reg ^ SIGN;
        up = {1'b0, yb} + {1'b0, quo_reg[63:0]};
        if (!neg_reg)
        begin
            if (quo_reg[127:64] != '0 || up[64]) sum_res = SIGN - 64'd1;
            else                                 sum_res = up[63:0] ^ SIGN;
        end
        else
        begin
            if (quo_reg[127:64] != '0 || quo_reg[63:0] > yb) sum_res = SIGN;
            else sum_res = (yb - quo_reg[63:0]) ^ SIGN;
        end
    end

    always_comb
    begin
        status_next = status_reg;
        if (cmd.load_req) status_next = stim_pkg::ST_OK;
        else if (cmd.set_unavail) status_next = stim_pkg::ST_UNAVAILABLE;
        else if (cmd.add_chk && add_rej) status_next = stim_pkg::ST_NOT_MONO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= stim_pkg::ST_OK;
            mul_ph_reg <= '0;
            bit_reg    <= '0;
        end
        else
        begin
            status_reg <= status_next;
            if (cmd.mul_go)
            begin
                mul_ph_reg <= 2'd0;
                bit_reg    <= 8'd133;
            end
            else if (cmd.div_step && bit_reg != '0)
            begin
                bit_reg <= bit_reg - 8'd1;
                if (mul_ph_reg != 2'd3) mul_ph_reg <= mul_ph_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg     <= in_data.opcode;
            s_reg      <= in_data.sample_index;
            t_reg      <= in_data.time_stamp;
            result_reg <= '0;
        end
        if (cmd.srch_init)
        begin
            lo_reg <= '0;
            hi_reg <= AW'(count_reg - CW'(1));
        end
        if (cmd.rd_mid) mid_reg <= mid_calc;
        if (cmd.srch_step)
        begin
            if (!slt(key, mid_x)) lo_reg <= mid_reg;
            else                  hi_reg <= mid_reg - AW'(1);
        end
        if (cmd.pair_clamp && ({1'b0, lo_reg} > (AW+1)'(count_reg - CW'(2))))
            lo_reg <= AW'(count_reg - CW'(2));
        if (cmd.rd_lo1)
        begin
            s0_reg <= rd_s_reg;
            t0_reg <= rd_t_reg;
        end
        if (cmd.one_cap)
        begin
            ma_reg        <= d1[63:0];
            neg_reg       <= d1[64];
            round_reg     <= 1'b0;
            span_zero_reg <= 1'b0;
            if (op_reg == stim_pkg::OP_S2T)
            begin
                mb_reg   <= TICK_SCALE;
                dv_reg   <= {16'd0, rate_cfg};
                base_reg <= rd_t_reg;
            end
            else
            begin
                mb_reg   <= {16'd0, rate_cfg};
                dv_reg   <= TICK_SCALE;
                base_reg <= rd_s_reg;
            end
        end
        if (cmd.mul_go)
        begin
            num_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            // 32x32 partial products in turn, then their sum, then 128 divide steps
            if (bit_reg > 8'd128)
            begin
                unique case (mul_ph_reg)
                    2'd0: pp_reg[0] <= ma_reg[31:0]  * mb_reg[31:0];
                    2'd1: pp_reg[1] <= ma_reg[31:0]  * mb_reg[63:32];
                    2'd2: pp_reg[2] <= ma_reg[63:32] * mb_reg[31:0];
                    2'd3: pp_reg[3] <= ma_reg[63:32] * mb_reg[63:32];
                    default: ;
                endcase
            end
            else if (bit_reg == 8'd128)
                num_reg <= {pp_reg[3], 64'd0} + {32'd0, pp_reg[2], 32'd0}
                         + {32'd0, pp_reg[1], 32'd0} + {64'd0, pp_reg[0]};
            else
            begin
                num_reg <= {num_reg[126:0], 1'b0};
                rem_reg <= q_bit ? rem_sub[63:0] : rem_sh[63:0];
                quo_reg <= {quo_reg[126:0], q_bit};
            end
        end
        if (cmd.do_round && round_reg && (rem_reg >= dv_reg - rem_reg))
            quo_reg <= quo_reg + 128'd1;
        if (cmd.do_sum)
            result_reg <= span_zero_reg ? base_reg : sum_res;
        if (cmd.pair_cap)
        begin
            ma_reg        <= dk[63:0];
            mb_reg        <= dt[63:0];
            dv_reg        <= ds[63:0];
            neg_reg       <= dk[64] ^ ds[64] ^ dt[64];
            round_reg     <= 1'b1;
            base_reg      <= y0;
            span_zero_reg <= (ds[63:0] == '0);
        end
    end

    assign st.opcode    = op_reg;
    assign st.cnt_zero  = (count_reg == '0);
    assign st.cnt_one   = (count_reg == CW'(1));
    assign st.rate_zero = (rate_cfg == '0);
    assign st.srch_done = (lo_reg >= hi_reg);
    assign st.div_done  = (bit_reg == 8'd0);
    assign st.span_zero = span_zero_reg;

    assign out_data.status       = status_reg;
    assign out_data.result_value = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count beyond depth");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(wr_en))
        else $error("entry count moved without a write");
    a_write_add: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> op_reg == stim_pkg::OP_ADD)
        else $error("table written by a lookup");

endmodule

// ----- hw/rtl/sample_time_interp_map.sv -----
// channel | direction | handshake          | payload
// in      | into      | in_valid/in_stall  | stim_pkg::in_item_t
// out     | out of    | out_valid/out_stall| stim_pkg::out_item_t
// cfg     | into      | cfg_valid/cfg_ready| 48-bit rate, Q32.16
//
// after acceptance, an add reads the last entry unless the table is empty; an unavailable
// result goes straight out; a single anchor lookup skips the search; a lookup with two or
// more anchors takes k search steps (at most ceil(log2(count))) and skips the divide on a
// zero-width interval; the bulk of a lookup is the serial 32x32 product and the radix-2 divider
// reset clears the entry count and the rate; anchor memories need no clear
// a new request is taken only once the previous result has left;
// out_stall holds the result register with its payload unchanged
module sample_time_interp_map #(
    parameter int unsigned     TABLE_DEPTH      = 1024,
    parameter longint unsigned TICKS_PER_SECOND = 64'd1073741824
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  stim_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output stim_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [47:0]         cfg_data
);

    // rate register, Q32.16 samples per second
    logic [47:0] rate_reg;

    stim_pkg::ctrl_t cmd;
    stim_pkg::stat_t st;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rate_reg <= '0;
        else if (cfg_valid && cfg_ready)
            rate_reg <= cfg_data;
    end

    // sequencer
    stim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // anchor tables, search, multiply and divide
    stim_datapath #(
        .TABLE_DEPTH      (TABLE_DEPTH),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (in_data),
        .rate_cfg    (rate_reg),
        .cmd         (cmd),
        .st          (st),
        .out_data    (out_data)
    );

endmodule

// ----- tb/sv/sample_time_interp_map_tb.sv -----
`timescale 1ns / 100ps

module sample_time_interp_map_tb;

    localparam int unsigned     DEPTH      = 1024;
    localparam longint unsigned TICKS      = 64'd1073741824;
    // ticks per second times the Q32.16 scale of the rate
    localparam bit [63:0]       RATE_SCALE = TICKS << 16;
    localparam bit [47:0]       RATE_MAX   = 48'hFFFF_FFFF_FFFF;
    localparam longint          CYCLE_LIMIT = 1500000;
    localparam longint signed   S64_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint signed   S64_MIN    = 64'sh8000_0000_0000_0000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    stim_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    stim_pkg::out_item_t out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [47:0]         cfg_data = '0;

    sample_time_interp_map dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // requests waiting to be driven, and results the table should still produce
    stim_pkg::in_item_t  req_queue[$];
    stim_pkg::out_item_t result_queue[$];

    // shadow of the anchor table and the rate register
    logic signed [63:0] anchor_smp[DEPTH];
    logic signed [63:0] anchor_tim[DEPTH];
    int unsigned        anchor_cnt = 0;
    bit [47:0]          rate_q16 = '0;

    int     fail_count = 0;
    longint cycle_count = 0;
    bit     calm = 1'b0;        // no idling on either side while set
    int     hold_seq = 0;       // bumped to ask the receiver for a long hold
    int     hold_seen = 0;
    int     hold_left = 0;
    logic   in_taken = 1'b0;

    // cursor for well-formed anchor sequences
    longint signed gen_s = 1000;
    longint signed gen_t = 5000;

    // magnitude of a - b and its sign
    function automatic bit [63:0] span_mag(logic signed [63:0] a, logic signed [63:0] b,
                                           output bit neg);
        neg = (a < b);
        return neg ? 64'(b - a) : 64'(a - b);
    endfunction

    // exact a*b/d, optionally rounded half up on the magnitude
    function automatic bit [127:0] scaled_quot(bit [63:0] a, bit [63:0] b, bit [63:0] d,
                                               bit rnd);
        bit [127:0] prod;
        bit [127:0] q;
        bit [127:0] r;
        prod = {64'd0, a} * {64'd0, b};
        q = prod / {64'd0, d};
        r = prod % {64'd0, d};
        if (rnd && r >= {64'd0, d} - r)
            q = q + 1;
        return q;
    endfunction

    // base plus or minus q, clipped to the signed 64-bit range
    function automatic logic signed [63:0] offset_sat(logic signed [63:0] base, bit neg,
                                                      bit [127:0] q);
        bit [63:0] biased;
        biased = base ^ 64'h8000_0000_0000_0000;
        if (!neg)
        begin
            if (q[127:64] != 0 || q[63:0] > ~biased)
                return S64_MAX;
            return (biased + q[63:0]) ^ 64'h8000_0000_0000_0000;
        end
        if (q[127:64] != 0 || q[63:0] > biased)
            return S64_MIN;
        return (biased - q[63:0]) ^ 64'h8000_0000_0000_0000;
    endfunction

    // piecewise-linear lookup; by_time selects time stamps as the search key
    function automatic logic signed [63:0] interp_lookup(logic signed [63:0] key, bit by_time);
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        mid;
        logic signed [63:0] x0;
        logic signed [63:0] x1;
        logic signed [63:0] y0;
        logic signed [63:0] y1;
        bit                 nk;
        bit                 ns;
        bit                 nt;
        bit [63:0]          dk;
        bit [63:0]          ds;
        bit [63:0]          dt;
        lo = 0;
        hi = anchor_cnt - 1;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if ((by_time ? anchor_tim[mid] : anchor_smp[mid]) <= key)
                lo = mid;
            else
                hi = mid - 1;
        end
        // extrapolate past the end with the last interval
        if (lo > anchor_cnt - 2)
            lo = anchor_cnt - 2;
        x0 = by_time ? anchor_tim[lo] : anchor_smp[lo];
        x1 = by_time ? anchor_tim[lo + 1] : anchor_smp[lo + 1];
        y0 = by_time ? anchor_smp[lo] : anchor_tim[lo];
        y1 = by_time ? anchor_smp[lo + 1] : anchor_tim[lo + 1];
        dk = span_mag(key, x0, nk);
        ds = span_mag(x1, x0, ns);
        dt = span_mag(y1, y0, nt);
        if (ds == 0)
            return y0;
        return offset_sat(y0, nk ^ ns ^ nt, scaled_quot(dk, dt, ds, 1'b1));
    endfunction

    // applies one request to the shadow table and returns the result it should give
    function automatic stim_pkg::out_item_t convert_request(stim_pkg::in_item_t r);
        stim_pkg::out_item_t o;
        int unsigned         n;
        logic signed [63:0]  s;
        logic signed [63:0]  t;
        bit                  neg;
        bit [63:0]           d;
        o = '0;
        s = r.sample_index;
        t = r.time_stamp;
        if (stim_pkg::opcode_t'(r.opcode) == stim_pkg::OP_ADD)
        begin
            // a full table judges the add against the slot before the last
            n = (anchor_cnt >= DEPTH) ? DEPTH - 1 : anchor_cnt;
            if (n > 0)
            begin
                if (s == anchor_smp[n - 1])
                    n = n - 1;
                else if (s < anchor_smp[n - 1])
                begin
                    o.status = stim_pkg::ST_NOT_MONO;
                    return o;
                end
            end
            anchor_smp[n] = s;
            anchor_tim[n] = t;
            anchor_cnt = n + 1;
            return o;
        end
        if (stim_pkg::opcode_t'(r.opcode) == stim_pkg::OP_RESERVED || anchor_cnt == 0 ||
            (anchor_cnt == 1 && rate_q16 == 0))
        begin
            o.status = stim_pkg::ST_UNAVAILABLE;
            return o;
        end
        if (anchor_cnt == 1)
        begin
            // single anchor: use the configured rate, truncated toward zero
            if (stim_pkg::opcode_t'(r.opcode) == stim_pkg::OP_S2T)
            begin
                d = span_mag(s, anchor_smp[0], neg);
                o.result_value = offset_sat(anchor_tim[0], neg,
                                            scaled_quot(d, RATE_SCALE, {16'd0, rate_q16}, 1'b0));
            end
            else
            begin
                d = span_mag(t, anchor_tim[0], neg);
                o.result_value = offset_sat(anchor_smp[0], neg,
                                            scaled_quot(d, {16'd0, rate_q16}, RATE_SCALE, 1'b0));
            end
            return o;
        end
        if (stim_pkg::opcode_t'(r.opcode) == stim_pkg::OP_S2T)
            o.result_value = interp_lookup(s, 1'b0);
        else
            o.result_value = interp_lookup(t, 1'b1);
        return o;
    endfunction

    task automatic push_req(stim_pkg::opcode_t op, longint signed s, longint signed t);
        stim_pkg::in_item_t r;
        r.opcode = op;
        r.sample_index = s;
        r.time_stamp = t;
        req_queue.push_back(r);
    endtask

    function automatic longint signed rand64();
        return {$urandom, $urandom};
    endfunction

    // one random request: mostly growing anchor sequences and in-range lookups
    task automatic push_random(int add_share);
        int            k;
        longint signed step;
        k = $urandom_range(99);
        if (k < add_share)
        begin
            if ($urandom_range(9) == 0)
                step = 0;                           // overwrite the last anchor
            else if ($urandom_range(19) == 0)
                step = $urandom;
            else
                step = $urandom_range(1, 1000);
            gen_s = gen_s + step;
            if ($urandom_range(7) == 0)
                gen_t = gen_t - $urandom_range(0, 3000);   // time going backward
            else
                gen_t = gen_t + $urandom_range(0, 100000);
            push_req(stim_pkg::OP_ADD, gen_s, gen_t);
        end
        else if (k < add_share + 30)
        begin
            push_req(stim_pkg::OP_S2T, gen_s - longint'($urandom) + $urandom_range(0, 3000),
                     rand64());
        end
        else if (k < add_share + 45)
        begin
            push_req(stim_pkg::OP_T2S, rand64(),
                     gen_t - longint'($urandom) + $urandom_range(0, 300000));
        end
        else if (k < add_share + 52)
        begin
            push_req($urandom_range(1) ? stim_pkg::OP_S2T : stim_pkg::OP_T2S, rand64(),
                     rand64());
        end
        else if ($urandom_range(1))
        begin
            // out-of-order add, rejected
            push_req(stim_pkg::OP_ADD, gen_s - $urandom_range(1, 1000000), rand64());
        end
        else
        begin
            push_req(stim_pkg::OP_RESERVED, rand64(), rand64());
        end
    endtask

    // sender pause: nothing more goes in until every result is back
    task automatic drain();
        while (req_queue.size() != 0 || in_valid || result_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_rate(bit [47:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        rate_q16 = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // run timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (req_queue.size() != 0 && (calm || $urandom_range(99) >= 29))
            begin
                in_data <= req_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall, with a long hold when asked
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_seen != hold_seq)
        begin
            hold_seen <= hold_seq;
            hold_left <= 400;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < 29);
    end

    // accepted requests feed the predictor; results are checked in order
    always @(posedge clk)
    begin
        stim_pkg::out_item_t want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                result_queue.push_back(convert_request(in_data));
            if (out_valid && !out_stall)
            begin
                if (result_queue.size() == 0)
                begin
                    $error("result with nothing expected: status %0d value %0d",
                           out_data.status, out_data.result_value);
                    fail_count++;
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.result_value !== want.result_value)
                    begin
                        $error("result_value: expected %0d, got %0d",
                               want.result_value, out_data.result_value);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        longint signed last_s;
        longint signed prev_s;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table, unknown rate
        write_rate('0);
        push_req(stim_pkg::OP_S2T, 0, 0);
        push_req(stim_pkg::OP_T2S, 0, 0);
        push_req(stim_pkg::OP_RESERVED, S64_MAX, S64_MIN);
        push_req(stim_pkg::OP_ADD, 100, 1000);
        push_req(stim_pkg::OP_S2T, 150, 0);           // one anchor without a rate
        push_req(stim_pkg::OP_T2S, 0, 2000);
        drain();

        // one anchor with the slowest rate
        write_rate(48'd1);
        push_req(stim_pkg::OP_S2T, 101, 0);
        push_req(stim_pkg::OP_S2T, 99, 0);
        push_req(stim_pkg::OP_T2S, 0, S64_MAX);
        push_req(stim_pkg::OP_T2S, 0, S64_MIN);
        drain();

        // fastest rate: single anchor extremes, then the first intervals
        write_rate(RATE_MAX);
        push_req(stim_pkg::OP_S2T, S64_MAX, 0);
        push_req(stim_pkg::OP_S2T, S64_MIN, 0);
        push_req(stim_pkg::OP_T2S, 0, S64_MAX);
        push_req(stim_pkg::OP_T2S, 0, S64_MIN);
        push_req(stim_pkg::OP_ADD, 100, -5);          // equal index overwrites
        push_req(stim_pkg::OP_S2T, 0, 0);
        push_req(stim_pkg::OP_ADD, 50, 7);            // smaller index rejected
        push_req(stim_pkg::OP_ADD, 200, -5);          // flat time span
        push_req(stim_pkg::OP_T2S, 0, -5);            // zero-width interval
        push_req(stim_pkg::OP_S2T, 150, 0);
        push_req(stim_pkg::OP_ADD, 300, S64_MAX);
        push_req(stim_pkg::OP_S2T, S64_MIN, 0);
        push_req(stim_pkg::OP_S2T, S64_MAX, 0);       // saturates
        push_req(stim_pkg::OP_T2S, 0, S64_MIN);
        push_req(stim_pkg::OP_RESERVED, 0, 0);
        drain();

        // random rate, random traffic, with a long receiver hold midway
        write_rate({16'($urandom_range(0, 65535)), $urandom});
        repeat (800) push_random(40);
        while (req_queue.size() > 400)
            @(posedge clk);
        hold_seq++;
        drain();

        // grow the table, no idling, then top it up until it is full
        write_rate('0);
        calm = 1'b1;
        repeat (300) push_random(92);
        drain();
        repeat (DEPTH - anchor_cnt + 4)
        begin
            gen_s = gen_s + $urandom_range(1, 1000);
            gen_t = gen_t + $urandom_range(0, 100000);
            push_req(stim_pkg::OP_ADD, gen_s, gen_t);
        end
        drain();
        calm = 1'b0;

        // full table: overwrite last, overwrite the one before, reject, replace
        write_rate({16'($urandom_range(0, 65535)), $urandom});
        last_s = anchor_smp[anchor_cnt - 1];
        prev_s = anchor_smp[anchor_cnt - 2];
        push_req(stim_pkg::OP_ADD, last_s, rand64());
        push_req(stim_pkg::OP_S2T, last_s + 10, 0);
        push_req(stim_pkg::OP_ADD, prev_s, gen_t);
        push_req(stim_pkg::OP_ADD, prev_s - 1, 0);
        push_req(stim_pkg::OP_ADD, last_s + 500, gen_t + 100000);
        push_req(stim_pkg::OP_T2S, 0, gen_t + 200000);
        repeat (30) push_random(30);
        drain();

        if (fail_count == 0 && result_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
